[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro names the assertion, takes the clock, the active-low reset,
// an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/sldp_pkg.sv]
// ----------------------------------------------------------------------------
// sldp_pkg
// Types and codes shared by the size line parser modules.
// ----------------------------------------------------------------------------
package sldp_pkg;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_MISSING   = 3'd3;
	localparam logic [2:0] ST_FORMAT    = 3'd4;
	localparam logic [2:0] ST_OBJECT    = 3'd5;
	localparam logic [2:0] ST_TOO_LONG  = 3'd6;

	// register indexes (word address)
	localparam logic [1:0] REG_OBJECT_KIND     = 2'd0;
	localparam logic [1:0] REG_STORAGE_FORMAT  = 2'd1;
	localparam logic [1:0] REG_MAX_LINE_LENGTH = 2'd2;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register reset values
	localparam logic [1:0]  OBJECT_KIND_RST     = 2'd0;
	localparam logic [1:0]  STORAGE_FORMAT_RST  = 2'd1;
	localparam logic [15:0] MAX_LINE_LENGTH_RST = 16'd2048;

	// object and format codes
	localparam logic [1:0] OBJ_MATRIX = 2'd0;
	localparam logic [1:0] OBJ_VECTOR = 2'd1;
	localparam logic [1:0] FMT_ARRAY  = 2'd0;
	localparam logic [1:0] FMT_COORD  = 2'd1;

	// characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [63:0] ABSENT = '1;

	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_WAIT   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  object_kind;
		logic [1:0]  storage_format;
		logic [15:0] max_line_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] row_count;
		logic [63:0] column_count;
		logic [63:0] nonzero_count;
	} result_t;

endpackage

[rtl/core/size_line_decimal_parser.sv]
// ----------------------------------------------------------------------------
// size_line_decimal_parser
// Size line parser: one byte per beat in, one result beat per newline or
// over-long line out. Input register, scanner, result register.
// Flow: a byte is registered in the input register, scanned there, and its
//   result is registered in the result register once the output is free.
// Throughput: one byte per cycle; stalls only while a result beat waits and
//   the next byte would also produce one.
// Reset: arst_n clears line state and handshake flags; registers return to
//   object 0, format 1, max line length 2048.
// ----------------------------------------------------------------------------
module size_line_decimal_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sldp_pkg::ADDR_W-1:0]  paddr,
	input  logic [sldp_pkg::DATA_W-1:0]  pwdata,
	output logic [sldp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         line_valid,
	output logic                         line_ready,
	input  logic [7:0]                   line_byte,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [2:0]                   status,
	output logic signed [63:0]           row_count,
	output logic signed [63:0]           column_count,
	output logic signed [63:0]           nonzero_count
);

	sldp_pkg::cfg_t    cfg;
	sldp_pkg::result_t res;
	sldp_pkg::result_t res_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              emit;
	logic              out_free;
	logic              step;
	logic              result_valid_q;

	sldp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sldp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.byte_s1 (byte_s1),
		.step    (step),
		.emit    (emit),
		.res     (res)
	);

	// a byte with no result never waits on the output side
	assign out_free   = !result_valid_q || result_ready;
	assign step       = valid_s1 && (!emit || out_free);
	assign line_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (line_valid && line_ready)
			valid_s1 <= 1'b1;
		else if (step)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (line_valid && line_ready)
			byte_s1 <= line_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (step && emit)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && emit)
			res_q <= res;
	end

	assign result_valid  = result_valid_q;
	assign status        = res_q.status;
	assign row_count     = res_q.row_count;
	assign column_count  = res_q.column_count;
	assign nonzero_count = res_q.nonzero_count;

endmodule

[rtl/core/sldp_cfg.sv]
// ----------------------------------------------------------------------------
// sldp_cfg
// APB register file: object kind, storage format and line length limit.
// ----------------------------------------------------------------------------
module sldp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sldp_pkg::ADDR_W-1:0]  paddr,
	input  logic [sldp_pkg::DATA_W-1:0]  pwdata,
	output logic [sldp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output sldp_pkg::cfg_t               cfg
);

	logic [1:0]  object_kind_q;
	logic [1:0]  storage_format_q;
	logic [15:0] max_line_length_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[sldp_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_kind_q     <= sldp_pkg::OBJECT_KIND_RST;
			storage_format_q  <= sldp_pkg::STORAGE_FORMAT_RST;
			max_line_length_q <= sldp_pkg::MAX_LINE_LENGTH_RST;
		end else if (wr_en) begin
			case (reg_idx)
				sldp_pkg::REG_OBJECT_KIND:     object_kind_q     <= pwdata[1:0];
				sldp_pkg::REG_STORAGE_FORMAT:  storage_format_q  <= pwdata[1:0];
				sldp_pkg::REG_MAX_LINE_LENGTH: max_line_length_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sldp_pkg::REG_OBJECT_KIND:     prdata = {30'd0, object_kind_q};
			sldp_pkg::REG_STORAGE_FORMAT:  prdata = {30'd0, storage_format_q};
			sldp_pkg::REG_MAX_LINE_LENGTH: prdata = {16'd0, max_line_length_q};
			default:                       prdata = '0;
		endcase
	end

	assign cfg.object_kind     = object_kind_q;
	assign cfg.storage_format  = storage_format_q;
	assign cfg.max_line_length = max_line_length_q;

endmodule

[rtl/core/sldp_core.sv]
// ----------------------------------------------------------------------------
// sldp_core
// Per-byte scanner: line state, number accumulation with overflow tracking,
// and result formation at newline or line length limit.
// ----------------------------------------------------------------------------
module sldp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  sldp_pkg::cfg_t      cfg,
	input  logic [7:0]          byte_s1,
	input  logic                step,
	output logic                emit,
	output sldp_pkg::result_t   res
);

	logic [1:0]       field_index_q, n_field_index;
	sldp_pkg::phase_t phase_q, n_phase;
	logic [63:0]      mag_q, n_mag;
	logic             neg_q, n_neg;
	logic             ovf_q, n_ovf;
	logic [63:0]      rows_q, n_rows;
	logic [63:0]      cols_q, n_cols;
	logic [2:0]       first_error_q, n_first_error;
	logic [15:0]      bytes_q, n_bytes;

	logic        is_nl, is_space, is_digit, is_sign;
	logic [16:0] bytes_inc;
	logic        too_long;
	logic [2:0]  needed;
	logic        is_last;
	logic [63:0] num_value;
	logic [67:0] mag_x10, digit_sum, lim;
	logic        ovf_hit;
	logic        clear_line;
	logic        fail_en;
	logic [2:0]  fail_st;
	logic [2:0]  eol_code, eol_err;
	logic [63:0] eol_v;

	assign is_nl    = (byte_s1 == sldp_pkg::CH_NL);
	assign is_space = byte_s1 inside {sldp_pkg::CH_SPACE, sldp_pkg::CH_TAB, sldp_pkg::CH_VT,
		sldp_pkg::CH_FF, sldp_pkg::CH_CR};
	assign is_digit = byte_s1 inside {[sldp_pkg::CH_ZERO:sldp_pkg::CH_NINE]};
	assign is_sign  = byte_s1 inside {sldp_pkg::CH_PLUS, sldp_pkg::CH_MINUS};

	assign bytes_inc = {1'b0, bytes_q} + 17'd1;
	assign too_long  = !is_nl && (bytes_inc >= {1'b0, cfg.max_line_length});
	assign emit      = is_nl || too_long;

	always_comb begin
		case (cfg.object_kind)
			sldp_pkg::OBJ_MATRIX: needed = (cfg.storage_format == sldp_pkg::FMT_COORD) ? 3'd3 : 3'd2;
			sldp_pkg::OBJ_VECTOR: needed = (cfg.storage_format == sldp_pkg::FMT_COORD) ? 3'd2 : 3'd1;
			default:              needed = 3'd1;
		endcase
	end

	assign is_last   = ({1'b0, field_index_q} + 3'd1) >= needed;
	assign num_value = neg_q ? (64'd0 - mag_q) : mag_q;

	// magnitude * 10 + digit, checked against the signed limit
	assign mag_x10   = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
	assign digit_sum = mag_x10 + {64'd0, byte_s1[3:0]};
	assign lim       = neg_q ? {4'd0, 1'b1, 63'd0} : {5'd0, {63{1'b1}}};
	assign ovf_hit   = digit_sum > lim;

	always_comb begin
		n_field_index = field_index_q;
		n_phase       = phase_q;
		n_mag         = mag_q;
		n_neg         = neg_q;
		n_ovf         = ovf_q;
		n_rows        = rows_q;
		n_cols        = cols_q;
		n_first_error = first_error_q;
		n_bytes       = bytes_inc[15:0];
		clear_line    = 1'b0;
		fail_en       = 1'b0;
		fail_st       = sldp_pkg::ST_OK;
		eol_code      = sldp_pkg::ST_OK;
		eol_err       = sldp_pkg::ST_OK;
		eol_v         = '0;
		res           = '0;

		if (is_nl) begin
			clear_line = 1'b1;
			case (phase_q)
				sldp_pkg::PH_SKIP, sldp_pkg::PH_SIGN: eol_code = sldp_pkg::ST_MISSING;
				sldp_pkg::PH_DIGITS: begin
					if (ovf_q)
						eol_code = sldp_pkg::ST_RANGE;
					else if (!is_last)
						eol_code = sldp_pkg::ST_MALFORMED;
					else
						eol_v = num_value;
				end
				default: ;
			endcase
			eol_err = (first_error_q != sldp_pkg::ST_OK) ? first_error_q : eol_code;

			if (cfg.object_kind > sldp_pkg::OBJ_VECTOR) begin
				res.status = sldp_pkg::ST_OBJECT;
			end else if (cfg.storage_format > sldp_pkg::FMT_COORD) begin
				res.status = sldp_pkg::ST_FORMAT;
			end else if (eol_err != sldp_pkg::ST_OK) begin
				res.status = eol_err;
			end else if (cfg.object_kind == sldp_pkg::OBJ_MATRIX) begin
				res.status    = sldp_pkg::ST_OK;
				res.row_count = rows_q;
				if (cfg.storage_format == sldp_pkg::FMT_ARRAY) begin
					res.column_count  = eol_v;
					res.nonzero_count = sldp_pkg::ABSENT;
				end else begin
					res.column_count  = cols_q;
					res.nonzero_count = eol_v;
				end
			end else begin
				res.status       = sldp_pkg::ST_OK;
				res.column_count = sldp_pkg::ABSENT;
				if (cfg.storage_format == sldp_pkg::FMT_ARRAY) begin
					res.row_count     = eol_v;
					res.nonzero_count = sldp_pkg::ABSENT;
				end else begin
					res.row_count     = rows_q;
					res.nonzero_count = eol_v;
				end
			end
		end else if (too_long) begin
			clear_line = 1'b1;
			res.status = sldp_pkg::ST_TOO_LONG;
		end else begin
			case (phase_q)
				sldp_pkg::PH_SKIP: begin
					if (is_space) begin
						n_phase = sldp_pkg::PH_SKIP;
					end else if (is_sign) begin
						n_neg   = (byte_s1 == sldp_pkg::CH_MINUS);
						n_phase = sldp_pkg::PH_SIGN;
					end else if (is_digit) begin
						n_phase = sldp_pkg::PH_DIGITS;
						if (!ovf_q) begin
							if (ovf_hit)
								n_ovf = 1'b1;
							else
								n_mag = digit_sum[63:0];
						end
					end else begin
						fail_en = 1'b1;
						fail_st = sldp_pkg::ST_MISSING;
					end
				end
				sldp_pkg::PH_SIGN: begin
					if (is_digit) begin
						n_phase = sldp_pkg::PH_DIGITS;
						if (!ovf_q) begin
							if (ovf_hit)
								n_ovf = 1'b1;
							else
								n_mag = digit_sum[63:0];
						end
					end else begin
						fail_en = 1'b1;
						fail_st = sldp_pkg::ST_MISSING;
					end
				end
				sldp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						if (!ovf_q) begin
							if (ovf_hit)
								n_ovf = 1'b1;
							else
								n_mag = digit_sum[63:0];
						end
					end else if (ovf_q) begin
						fail_en = 1'b1;
						fail_st = sldp_pkg::ST_RANGE;
					end else if (is_last || byte_s1 != sldp_pkg::CH_SPACE) begin
						fail_en = 1'b1;
						fail_st = sldp_pkg::ST_MALFORMED;
					end else begin
						// save the finished number and move to the next
						if (field_index_q == 2'd0)
							n_rows = num_value;
						else
							n_cols = num_value;
						n_field_index = field_index_q + 2'd1;
						n_mag         = '0;
						n_neg         = 1'b0;
						n_ovf         = 1'b0;
						n_phase       = sldp_pkg::PH_SKIP;
					end
				end
				default: ;
			endcase
			if (fail_en) begin
				// keep only the first error of the line
				if (first_error_q == sldp_pkg::ST_OK)
					n_first_error = fail_st;
				n_phase = sldp_pkg::PH_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= '0;
			phase_q       <= sldp_pkg::PH_SKIP;
			mag_q         <= '0;
			neg_q         <= 1'b0;
			ovf_q         <= 1'b0;
			rows_q        <= '0;
			cols_q        <= '0;
			first_error_q <= sldp_pkg::ST_OK;
			bytes_q       <= '0;
		end else if (step) begin
			if (clear_line) begin
				field_index_q <= '0;
				phase_q       <= sldp_pkg::PH_SKIP;
				mag_q         <= '0;
				neg_q         <= 1'b0;
				ovf_q         <= 1'b0;
				rows_q        <= '0;
				cols_q        <= '0;
				first_error_q <= sldp_pkg::ST_OK;
				bytes_q       <= '0;
			end else begin
				field_index_q <= n_field_index;
				phase_q       <= n_phase;
				mag_q         <= n_mag;
				neg_q         <= n_neg;
				ovf_q         <= n_ovf;
				rows_q        <= n_rows;
				cols_q        <= n_cols;
				first_error_q <= n_first_error;
				bytes_q       <= n_bytes;
			end
		end
	end

endmodule

[rtl/core/sldp_checker.sv]
// ----------------------------------------------------------------------------
// sldp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sldp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  status,
	input logic [63:0] row_count,
	input logic [63:0] column_count,
	input logic [63:0] nonzero_count
);

	// a waiting result beat holds
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(status) && $stable(row_count))

	// status codes stop at too long
	`ASSERT_SAME(a_status_range, clk, arst_n, result_valid, status <= sldp_pkg::ST_TOO_LONG)

	// an error result carries no counts
	`ASSERT_SAME(a_error_zero, clk, arst_n, result_valid && status != sldp_pkg::ST_OK, row_count == 64'd0 && column_count == 64'd0 && nonzero_count == 64'd0)

	// result valid is always known out of reset
	`ASSERT_SAME(a_valid_known, clk, arst_n, 1'b1, !$isunknown(result_valid))

endmodule

bind size_line_decimal_parser sldp_checker u_sldp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.status        (status),
	.row_count     (row_count),
	.column_count  (column_count),
	.nonzero_count (nonzero_count)
);
